[sv/assert_macros.svh]
// assertion macros used by fdbb_queue
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[sv/fdbb_pkg.sv]
// shared types and constants of the frame damage bounding box unit
// no dependencies
package fdbb_pkg;

   localparam int MAX_SLOTS_DEFAULT = 16;
   localparam int QUEUE_DEPTH       = 4;
   localparam int COORD_W           = 16;
   localparam int GEN_W             = 32;
   localparam int EDGE_W            = 18;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_CANVAS_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CANVAS_HEIGHT = 2'd1;

   // rectangle as half-open edges, wide enough for x + w
   typedef struct packed {
      logic signed [EDGE_W-1:0] x0;
      logic signed [EDGE_W-1:0] y0;
      logic signed [EDGE_W-1:0] x1;
      logic signed [EDGE_W-1:0] y1;
   } rect_type;

   // classified slot handed from front to back
   typedef struct packed {
      logic     old_en;
      rect_type old_rect;
      logic     new_en;
      rect_type new_rect;
      logic     eof;
      logic     whole;
   } work_type;

endpackage

[sv/fdbb_front.sv]
// front end: slot table, slot counter and change classification
// depends on fdbb_pkg
module fdbb_front #(
   parameter int MAX_SLOTS = fdbb_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic                                  slot_armed,
   input  logic signed [fdbb_pkg::COORD_W-1:0]   slot_x,
   input  logic signed [fdbb_pkg::COORD_W-1:0]   slot_y,
   input  logic        [fdbb_pkg::COORD_W-1:0]   slot_w,
   input  logic        [fdbb_pkg::COORD_W-1:0]   slot_h,
   input  logic        [fdbb_pkg::GEN_W-1:0]     slot_generation,
   input  logic                                  end_of_frame,
   output fdbb_pkg::work_type                    work
);
   import fdbb_pkg::*;

   localparam int CNT_W = $clog2(MAX_SLOTS + 2);
   localparam int PRI_W = $clog2(MAX_SLOTS + 1);
   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   logic [CNT_W-1:0] counter_ff, counter_in;
   logic [PRI_W-1:0] prior_count_ff, prior_count_in;

   logic [MAX_SLOTS-1:0]      tbl_armed_ff;
   logic signed [COORD_W-1:0] tbl_x_ff   [MAX_SLOTS];
   logic signed [COORD_W-1:0] tbl_y_ff   [MAX_SLOTS];
   logic [COORD_W-1:0]        tbl_w_ff   [MAX_SLOTS];
   logic [COORD_W-1:0]        tbl_h_ff   [MAX_SLOTS];
   logic [GEN_W-1:0]          tbl_gen_ff [MAX_SLOTS];

   logic [IDX_W-1:0] idx;
   logic             in_table;
   logic             p_armed;
   logic             changed;
   logic             whole;

   assign idx      = counter_ff[IDX_W-1:0];
   assign in_table = (counter_ff < CNT_W'(MAX_SLOTS));
   assign p_armed  = tbl_armed_ff[idx];

   always_comb begin
      changed = in_table && ((p_armed != slot_armed) ||
                (slot_armed && ((tbl_x_ff[idx] != slot_x) || (tbl_y_ff[idx] != slot_y) ||
                                (tbl_w_ff[idx] != slot_w) || (tbl_h_ff[idx] != slot_h) ||
                                (tbl_gen_ff[idx] != slot_generation))));

      // saturating slot count, one past capacity marks overflow
      counter_in = (counter_ff <= CNT_W'(MAX_SLOTS)) ? counter_ff + 1'b1 : counter_ff;

      whole = (counter_in > CNT_W'(MAX_SLOTS)) || (prior_count_ff == '0) ||
              (CNT_W'(prior_count_ff) != counter_in);
      prior_count_in = (counter_in > CNT_W'(MAX_SLOTS)) ? '0 : counter_in[PRI_W-1:0];

      work.old_en      = changed && p_armed && (tbl_w_ff[idx] != '0) && (tbl_h_ff[idx] != '0);
      work.old_rect.x0 = EDGE_W'(tbl_x_ff[idx]);
      work.old_rect.y0 = EDGE_W'(tbl_y_ff[idx]);
      work.old_rect.x1 = EDGE_W'(tbl_x_ff[idx]) + $signed(EDGE_W'(tbl_w_ff[idx]));
      work.old_rect.y1 = EDGE_W'(tbl_y_ff[idx]) + $signed(EDGE_W'(tbl_h_ff[idx]));
      work.new_en      = changed && slot_armed && (slot_w != '0) && (slot_h != '0);
      work.new_rect.x0 = EDGE_W'(slot_x);
      work.new_rect.y0 = EDGE_W'(slot_y);
      work.new_rect.x1 = EDGE_W'(slot_x) + $signed(EDGE_W'(slot_w));
      work.new_rect.y1 = EDGE_W'(slot_y) + $signed(EDGE_W'(slot_h));
      work.eof         = end_of_frame;
      work.whole       = whole;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff     <= '0;
         prior_count_ff <= '0;
      end else if (accept) begin
         if (end_of_frame) begin
            counter_ff     <= '0;
            prior_count_ff <= prior_count_in;
         end else begin
            counter_ff <= counter_in;
         end
      end
   end

   // slot table, no reset: entries not yet written are only read in frames that repaint all
   always_ff @(posedge clock) begin
      if (accept && in_table) begin
         tbl_armed_ff[idx] <= slot_armed;
         tbl_x_ff[idx]     <= slot_x;
         tbl_y_ff[idx]     <= slot_y;
         tbl_w_ff[idx]     <= slot_w;
         tbl_h_ff[idx]     <= slot_h;
         tbl_gen_ff[idx]   <= slot_generation;
      end
   end

endmodule

[sv/fdbb_queue.sv]
// short fifo of classified slots between front and back
// depends on fdbb_pkg and assert_macros.svh
`include "assert_macros.svh"
module fdbb_queue #(
   parameter int DEPTH = fdbb_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fdbb_pkg::work_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output fdbb_pkg::work_type pop_data
);
   import fdbb_pkg::*;

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   work_type           slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == COUNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slots_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_CLK(a_count_bound, clock, reset, (count_ff <= COUNT_W'(DEPTH)), "queue count over depth")
   `ASSERT_CLK(a_push_only, clock, reset, (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1), "push did not count up")
   `ASSERT_CLK(a_pop_only, clock, reset, (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1), "pop did not count down")

endmodule

[sv/fdbb_back.sv]
// back end: running bounding box, frame-end clamp and result register
// depends on fdbb_pkg
module fdbb_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [fdbb_pkg::COORD_W-1:0]      canvas_width,
   input  logic [fdbb_pkg::COORD_W-1:0]      canvas_height,
   input  logic                              work_valid,
   input  fdbb_pkg::work_type                work,
   output logic                              work_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fdbb_pkg::COORD_W-1:0]      rsp_damage_x,
   output logic [fdbb_pkg::COORD_W-1:0]      rsp_damage_y,
   output logic [fdbb_pkg::COORD_W-1:0]      rsp_damage_w,
   output logic [fdbb_pkg::COORD_W-1:0]      rsp_damage_h
);
   import fdbb_pkg::*;

   typedef struct packed {
      logic     valid;
      rect_type rect;
   } box_type;

   box_type box_ff, box_mid, box_fin;
   logic    rsp_valid_ff;
   logic [COORD_W-1:0] dx_ff, dy_ff, dw_ff, dh_ff;
   logic [COORD_W-1:0] dx_in, dy_in, dw_in, dh_in;
   logic signed [EDGE_W-1:0] cw_ext, ch_ext, cx0, cy0, cx1, cy1;

   function automatic box_type widen_box(box_type b, logic en, rect_type r);
      box_type res;
      res = b;
      if (en) begin
         if (!b.valid) begin
            res.valid = 1'b1;
            res.rect  = r;
         end else begin
            if (r.x0 < b.rect.x0) res.rect.x0 = r.x0;
            if (r.y0 < b.rect.y0) res.rect.y0 = r.y0;
            if (r.x1 > b.rect.x1) res.rect.x1 = r.x1;
            if (r.y1 > b.rect.y1) res.rect.y1 = r.y1;
         end
      end
      return res;
   endfunction

   // a frame end needs the result register free or draining
   assign work_pop = work_valid && (!work.eof || !rsp_valid_ff || rsp_ready);

   always_comb begin
      box_mid = widen_box(box_ff, work.old_en, work.old_rect);
      box_fin = widen_box(box_mid, work.new_en, work.new_rect);

      cw_ext = $signed({{(EDGE_W-COORD_W){1'b0}}, canvas_width});
      ch_ext = $signed({{(EDGE_W-COORD_W){1'b0}}, canvas_height});
      cx0 = (box_fin.rect.x0 > 0) ? box_fin.rect.x0 : '0;
      cy0 = (box_fin.rect.y0 > 0) ? box_fin.rect.y0 : '0;
      cx1 = (box_fin.rect.x1 < cw_ext) ? box_fin.rect.x1 : cw_ext;
      cy1 = (box_fin.rect.y1 < ch_ext) ? box_fin.rect.y1 : ch_ext;

      dx_in = '0;
      dy_in = '0;
      dw_in = '0;
      dh_in = '0;
      if (work.whole) begin
         dw_in = canvas_width;
         dh_in = canvas_height;
      end else if (box_fin.valid && (cx1 > cx0) && (cy1 > cy0)) begin
         dx_in = cx0[COORD_W-1:0];
         dy_in = cy0[COORD_W-1:0];
         dw_in = COORD_W'(cx1 - cx0);
         dh_in = COORD_W'(cy1 - cy0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (work_pop) begin
            box_ff.valid <= work.eof ? 1'b0 : box_fin.valid;
            box_ff.rect  <= box_fin.rect;
         end
         if (work_pop && work.eof) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (work_pop && work.eof) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dw_ff <= dw_in;
         dh_ff <= dh_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_damage_x = dx_ff;
   assign rsp_damage_y = dy_ff;
   assign rsp_damage_w = dw_ff;
   assign rsp_damage_h = dh_ff;

endmodule

[sv/frame_damage_bounding_box_unit.sv]
// top level of the frame damage bounding box unit
// depends on fdbb_pkg, fdbb_front, fdbb_queue and fdbb_back
//
// usage:
//   req_* carries one overlay slot per item; end_of_frame marks the frame's last slot.
//   rsp_* carries one damage rectangle per frame, none for other slots.
//   csr_* writes canvas_width (index 0) and canvas_height (index 1); other
//   indexes are ignored. write only while the block is idle.
// timing:
//   one slot per cycle sustained while req_ready is high; a slot enters the queue at the
//   edge that accepts it and the back end pops it from the queue head, so the result of
//   a frame is registered in the output register when its last slot is popped.
//   the slot table read and compare in the front end sets the per-item cost.
// stalls:
//   when rsp_ready is low the result waits in the output register; the back end
//   keeps widening the next frame's box until it reaches the next frame end,
//   then the queue fills and req_ready drops.
// reset:
//   synchronous; clears counters, queue and result valid; canvas size becomes
//   zero and the next frame repaints the whole canvas.
module frame_damage_bounding_box_unit #(
   parameter int MAX_SLOTS   = fdbb_pkg::MAX_SLOTS_DEFAULT,
   parameter int QUEUE_DEPTH = fdbb_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_slot_armed,
   input  logic signed [fdbb_pkg::COORD_W-1:0] req_slot_x,
   input  logic signed [fdbb_pkg::COORD_W-1:0] req_slot_y,
   input  logic        [fdbb_pkg::COORD_W-1:0] req_slot_w,
   input  logic        [fdbb_pkg::COORD_W-1:0] req_slot_h,
   input  logic        [fdbb_pkg::GEN_W-1:0]   req_slot_generation,
   input  logic                                req_end_of_frame,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fdbb_pkg::COORD_W-1:0]        rsp_damage_x,
   output logic [fdbb_pkg::COORD_W-1:0]        rsp_damage_y,
   output logic [fdbb_pkg::COORD_W-1:0]        rsp_damage_w,
   output logic [fdbb_pkg::COORD_W-1:0]        rsp_damage_h,
   input  logic                                csr_write_enable,
   input  logic [fdbb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fdbb_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import fdbb_pkg::*;

   logic [COORD_W-1:0] canvas_width_ff, canvas_height_ff;
   logic               accept;
   logic               queue_full;
   logic               queue_valid;
   logic               queue_pop;
   work_type           front_work;
   work_type           back_work;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= '0;
         canvas_height_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CANVAS_WIDTH:  canvas_width_ff  <= csr_write_data[COORD_W-1:0];
            CSR_CANVAS_HEIGHT: canvas_height_ff <= csr_write_data[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // the front end never stalls on its own, only on a full queue
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   fdbb_front #(.MAX_SLOTS(MAX_SLOTS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .slot_armed      (req_slot_armed),
      .slot_x          (req_slot_x),
      .slot_y          (req_slot_y),
      .slot_w          (req_slot_w),
      .slot_h          (req_slot_h),
      .slot_generation (req_slot_generation),
      .end_of_frame    (req_end_of_frame),
      .work            (front_work)
   );

   fdbb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_work),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_valid (queue_valid),
      .pop_data  (back_work)
   );

   fdbb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .canvas_width  (canvas_width_ff),
      .canvas_height (canvas_height_ff),
      .work_valid    (queue_valid),
      .work          (back_work),
      .work_pop      (queue_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_damage_x  (rsp_damage_x),
      .rsp_damage_y  (rsp_damage_y),
      .rsp_damage_w  (rsp_damage_w),
      .rsp_damage_h  (rsp_damage_h)
   );

endmodule
